// ===== design/rpfa_pkg.sv =====
// shared types, constants and codes of the page frame allocator
package rpfa_pkg;

  localparam int NUM_FRAMES    = 4096;
  localparam int BYTES_PER_ROW = 8;
  localparam int BSEL_W        = 3;
  localparam int ROWS          = (NUM_FRAMES + BYTES_PER_ROW - 1) / BYTES_PER_ROW;
  localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W         = ROW_W + BSEL_W;
  localparam int COUNT_W       = 8;
  localparam int ROW_BITS      = BYTES_PER_ROW * COUNT_W;
  localparam int CFG_W         = 25;
  localparam int PAGE_W        = 20;
  localparam int SPAN_W        = CFG_W - 12;
  localparam int RNG_W         = (IDX_W >= 14) ? IDX_W + 1 : 14;

  localparam logic [CFG_W-1:0]   LOW_LINE  = CFG_W'(32'h0010_0000);
  localparam logic [PAGE_W-1:0]  LOW_PAGE  = PAGE_W'(32'h0000_0100);
  localparam logic [31:0]        LOW_BASE  = 32'h0010_0000;
  localparam logic [COUNT_W-1:0] RESERVED  = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_W-1:0] START_MEM_RST = CFG_W'(32'h0010_0000);
  localparam logic [CFG_W-1:0] END_MEM_RST   = CFG_W'(32'h0100_0000);

  // configuration register indexes
  localparam logic REG_START_MEM = 1'b0;
  localparam logic REG_END_MEM   = 1'b1;

  // command codes
  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_ADDREF = 3'd2;
  localparam logic [2:0] CMD_COW   = 3'd3;
  localparam logic [2:0] CMD_INIT  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OOM      = 3'd1;
  localparam logic [2:0] ST_LOW      = 3'd2;
  localparam logic [2:0] ST_NOEXIST  = 3'd3;
  localparam logic [2:0] ST_DBL_FREE = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        frame_address;
    logic               reused;
    logic [COUNT_W-1:0] ref_count;
  } out_item_t;

  typedef struct packed {
    logic                     rd_en;
    logic                     wr_en;
    logic [ROW_W-1:0]         addr;
    logic [BYTES_PER_ROW-1:0] be;
    logic [ROW_BITS-1:0]      wdata;
  } mem_req_t;

endpackage

// ===== design/rpfa_ram.sv =====
// count table: rows of eight 8-bit counts, byte write enables, registered read
module rpfa_ram import rpfa_pkg::*; (
  input  logic                clk_i,
  input  mem_req_t            req_i,
  output logic [ROW_BITS-1:0] rdata_o
);

  logic [ROW_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      for (int b = 0; b < BYTES_PER_ROW; b++) begin
        if (req_i.be[b]) begin
          mem[req_i.addr][COUNT_W*b +: COUNT_W] <= req_i.wdata[COUNT_W*b +: COUNT_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

// ===== design/rpfa_zfind.sv =====
// finds the highest tracked zero count within one row of the table
module rpfa_zfind import rpfa_pkg::*; (
  input  logic [ROW_W-1:0]    row_i,
  input  logic [ROW_BITS-1:0] data_i,
  output logic                found_o,
  output logic [BSEL_W-1:0]   pos_o
);

  always_comb begin
    logic [IDX_W:0] ent;
    found_o = 1'b0;
    pos_o   = '0;
    for (int b = 0; b < BYTES_PER_ROW; b++) begin
      ent = {1'b0, row_i, BSEL_W'(b)};
      // padding entries past the last frame are never handed out
      if (data_i[COUNT_W*b +: COUNT_W] == '0 && ent < (IDX_W+1)'(NUM_FRAMES)) begin
        found_o = 1'b1;
        pos_o   = BSEL_W'(b);
      end
    end
  end

endmodule

// ===== design/rpfa_ctrl.sv =====
// command sequencer: decode, read-modify-write of counts, free-frame scan, table sweep
module rpfa_ctrl import rpfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  in_item_t            in_data_i,
  output logic                in_stall_o,
  input  logic [CFG_W-1:0]    start_mem_i,
  input  logic [CFG_W-1:0]    end_mem_i,
  output mem_req_t            mem_req_o,
  input  logic [ROW_BITS-1:0] mem_rdata_i,
  output logic                res_valid_o,
  output out_item_t           res_o,
  input  logic                res_take_i
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [2:0]         cmd_q, cmd_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic               below_q, below_d;
  logic               tracked_q, tracked_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0] old_q, old_d;
  logic [ROW_W-1:0]   scan_row_q, scan_row_d;
  logic               scan_go_q, scan_go_d;
  logic               rv_q, rv_d;
  logic [ROW_W-1:0]   rrow_q, rrow_d;
  logic [ROW_W-1:0]   sweep_row_q, sweep_row_d;
  logic               sweep_init_q, sweep_init_d;
  logic [RNG_W-1:0]   lo_q, lo_d;
  logic [RNG_W-1:0]   hi_q, hi_d;
  out_item_t          res_q, res_d;

  logic              zf_found;
  logic [BSEL_W-1:0] zf_pos;

  rpfa_zfind u_zfind (
    .row_i   (rrow_q),
    .data_i  (mem_rdata_i),
    .found_o (zf_found),
    .pos_o   (zf_pos)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    logic [PAGE_W-1:0]  pg;
    logic [PAGE_W-1:0]  diff;
    logic               blw;
    logic               trk;
    logic [CFG_W-1:0]   s;
    logic [CFG_W-1:0]   span;
    logic [CFG_W-1:0]   base;
    logic [COUNT_W-1:0] cnt;
    logic               ge_end;
    logic [IDX_W-1:0]   nidx;
    logic [RNG_W-1:0]   f;

    state_d      = state_q;
    cmd_d        = cmd_q;
    page_d       = page_q;
    below_d      = below_q;
    tracked_d    = tracked_q;
    idx_d        = idx_q;
    old_d        = old_q;
    scan_row_d   = scan_row_q;
    scan_go_d    = scan_go_q;
    rv_d         = rv_q;
    rrow_d       = rrow_q;
    sweep_row_d  = sweep_row_q;
    sweep_init_d = sweep_init_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_d        = res_q;
    mem_req_o    = '0;

    pg   = in_data_i.address[31:12];
    blw  = (pg < LOW_PAGE);
    diff = pg - LOW_PAGE;
    trk  = !blw && (diff < PAGE_W'(NUM_FRAMES));

    s    = (start_mem_i < LOW_LINE) ? LOW_LINE : start_mem_i;
    span = (end_mem_i > s) ? (end_mem_i - s) : '0;
    base = s - LOW_LINE;

    cnt    = mem_rdata_i[{idx_q[BSEL_W-1:0], 3'b000} +: COUNT_W];
    ge_end = ({page_q, 12'h000} >= {7'h00, end_mem_i});
    nidx   = {rrow_q, zf_pos};
    f      = '0;

    case (state_q)
      S_SWEEP: begin
        // one row a cycle: counts inside the init range go to zero, the rest reserved
        mem_req_o.wr_en = 1'b1;
        mem_req_o.addr  = sweep_row_q;
        mem_req_o.be    = '1;
        for (int b = 0; b < BYTES_PER_ROW; b++) begin
          f = RNG_W'({sweep_row_q, BSEL_W'(b)});
          mem_req_o.wdata[COUNT_W*b +: COUNT_W] = (f >= lo_q && f < hi_q) ? '0 : RESERVED;
        end
        sweep_row_d = sweep_row_q + ROW_W'(1);
        if (sweep_row_q == ROW_W'(ROWS - 1)) begin
          state_d = sweep_init_q ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_data_i.cmd;
          page_d    = pg;
          below_d   = blw;
          tracked_d = trk;
          idx_d     = diff[IDX_W-1:0];
          old_d     = '0;
          res_d     = '0;
          case (in_data_i.cmd)
            CMD_ALLOC: begin
              scan_row_d = ROW_W'(ROWS - 1);
              scan_go_d  = 1'b1;
              rv_d       = 1'b0;
              state_d    = S_SCAN;
            end
            CMD_FREE, CMD_ADDREF, CMD_COW: begin
              mem_req_o.rd_en = trk;
              mem_req_o.addr  = diff[IDX_W-1:BSEL_W];
              state_d         = S_LOOK;
            end
            CMD_INIT: begin
              lo_d         = RNG_W'(base[CFG_W-1:12]);
              hi_d         = RNG_W'(base[CFG_W-1:12]) + RNG_W'(span[CFG_W-1:12]);
              sweep_row_d  = '0;
              sweep_init_d = 1'b1;
              state_d      = S_SWEEP;
            end
            default: begin
              res_d.status = ST_LOW;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      S_LOOK: begin
        mem_req_o.addr = idx_q[IDX_W-1:BSEL_W];
        mem_req_o.be   = BYTES_PER_ROW'(1) << idx_q[BSEL_W-1:0];
        state_d        = S_DONE;
        case (cmd_q)
          CMD_FREE: begin
            if (below_q) begin
              res_d.status = ST_LOW;
            end else if (ge_end || !tracked_q) begin
              res_d.status = ST_NOEXIST;
            end else if (cnt == '0) begin
              res_d.status = ST_DBL_FREE;
            end else begin
              mem_req_o.wr_en     = 1'b1;
              mem_req_o.wdata     = {BYTES_PER_ROW{cnt - COUNT_W'(1)}};
              res_d.ref_count     = cnt - COUNT_W'(1);
            end
          end
          CMD_ADDREF: begin
            if (below_q) begin
              res_d.status = ST_LOW;
            end else if (!tracked_q) begin
              res_d.status = ST_NOEXIST;
            end else if (cnt == COUNT_MAX) begin
              res_d.status    = ST_SAT;
              res_d.ref_count = COUNT_MAX;
            end else begin
              mem_req_o.wr_en = 1'b1;
              mem_req_o.wdata = {BYTES_PER_ROW{cnt + COUNT_W'(1)}};
              res_d.ref_count = cnt + COUNT_W'(1);
            end
          end
          default: begin
            // copy on write: a sole owner keeps its frame
            if (tracked_q && cnt == COUNT_W'(1)) begin
              res_d.frame_address = {page_q, 12'h000};
              res_d.reused        = 1'b1;
              res_d.ref_count     = COUNT_W'(1);
            end else begin
              old_d      = tracked_q ? cnt : '0;
              scan_row_d = ROW_W'(ROWS - 1);
              scan_go_d  = 1'b1;
              rv_d       = 1'b0;
              state_d    = S_SCAN;
            end
          end
        endcase
      end

      S_SCAN: begin
        if (rv_q && zf_found) begin
          mem_req_o.wr_en     = 1'b1;
          mem_req_o.addr      = rrow_q;
          mem_req_o.be        = BYTES_PER_ROW'(1) << zf_pos;
          mem_req_o.wdata     = {BYTES_PER_ROW{COUNT_W'(1)}};
          rv_d                = 1'b0;
          res_d.frame_address = (32'(nidx) << 12) + LOW_BASE;
          state_d             = S_DONE;
          if (cmd_q == CMD_ALLOC) begin
            res_d.ref_count = COUNT_W'(1);
          end else if (!tracked_q) begin
            res_d.ref_count = '0;
          end else if (old_q != '0) begin
            res_d.ref_count = old_q - COUNT_W'(1);
            state_d         = S_DEC;
          end else begin
            // the old frame had no users, so the scan may have handed it out again
            res_d.ref_count = (nidx == idx_q) ? COUNT_W'(1) : '0;
          end
        end else if (rv_q && rrow_q == '0) begin
          rv_d            = 1'b0;
          res_d.status    = ST_OOM;
          res_d.ref_count = old_q;
          state_d         = S_DONE;
        end else begin
          // one row read per cycle, highest row first
          mem_req_o.rd_en = scan_go_q;
          mem_req_o.addr  = scan_row_q;
          rv_d            = scan_go_q;
          rrow_d          = scan_row_q;
          scan_row_d      = scan_row_q - ROW_W'(1);
          scan_go_d       = scan_go_q && (scan_row_q != '0);
        end
      end

      S_DEC: begin
        mem_req_o.wr_en = 1'b1;
        mem_req_o.addr  = idx_q[IDX_W-1:BSEL_W];
        mem_req_o.be    = BYTES_PER_ROW'(1) << idx_q[BSEL_W-1:0];
        mem_req_o.wdata = {BYTES_PER_ROW{old_q - COUNT_W'(1)}};
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (sweep_init_q) begin
          res_d = '0;
        end
        if (res_take_i) begin
          sweep_init_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      scan_go_q    <= 1'b0;
      rv_q         <= 1'b0;
      sweep_row_q  <= '0;
      sweep_init_q <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
    end else begin
      state_q      <= state_d;
      scan_go_q    <= scan_go_d;
      rv_q         <= rv_d;
      sweep_row_q  <= sweep_row_d;
      sweep_init_q <= sweep_init_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    page_q     <= page_d;
    below_q    <= below_d;
    tracked_q  <= tracked_d;
    idx_q      <= idx_d;
    old_q      <= old_d;
    scan_row_q <= scan_row_d;
    rrow_q     <= rrow_d;
    res_q      <= res_d;
  end

endmodule

// ===== design/refcounted_page_frame_allocator.sv =====
// Reference-counted page frame allocator: one 8-bit count per 4 KB frame above 1 MB, kept in a
// single-port table of 8-count rows. After reset the block sweeps the table to the reserved
// value, one row a cycle, and stalls its input meanwhile. One transaction is worked at a
// time. free and add_ref read the count, modify it and write it back; a reused copy_on_write
// only reads it. alloc and a copying copy_on_write scan the table from the top, one row per
// cycle through the read port (copy_on_write looks up the old count first), and report out
// of memory when no frame is free; a copying copy_on_write then decrements the old frame's
// count when it had users. init rewrites the whole table, one row a cycle. A finished result
// waits in the output register while the next transaction is accepted.
module refcounted_page_frame_allocator import rpfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0]    start_mem_q, end_mem_q;
  logic                out_valid_q;
  out_item_t           out_data_q;
  mem_req_t            mem_req;
  logic [ROW_BITS-1:0] mem_rdata;
  logic                res_valid;
  out_item_t           res;
  logic                res_take;

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mem_q <= START_MEM_RST;
      end_mem_q   <= END_MEM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_MEM: start_mem_q <= cfg_data_i;
        REG_END_MEM:   end_mem_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  rpfa_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .start_mem_i (start_mem_q),
    .end_mem_i   (end_mem_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // output register holds a result until the consumer takes it (out_stall_i low)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
